>>> hw/rtl/gaior_pkg.sv
// ----------------------------------------------------------------------------
// gaior_pkg
// Shared types and codes for the graphics adapter I/O register block.
// ----------------------------------------------------------------------------
package gaior_pkg;

  localparam int unsigned AttrRegs = 32;
  localparam int unsigned SeqRegs  = 8;
  localparam int unsigned GfxRegs  = 16;

  localparam int unsigned AttrIdxW = $clog2(AttrRegs);
  localparam int unsigned SeqIdxW  = $clog2(SeqRegs);
  localparam int unsigned GfxIdxW  = $clog2(GfxRegs);

  localparam logic [7:0] ByteOnes = 8'hFF;

  typedef enum logic [1:0] {
    CMD_IO_READ  = 2'd0,
    CMD_IO_WRITE = 2'd1,
    CMD_HSYNC    = 2'd2,
    CMD_VSYNC    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CRTC_NONE      = 2'd0,
    CRTC_ADDR_WR   = 2'd1,
    CRTC_DATA_WR   = 2'd2,
    CRTC_DATA_RD   = 2'd3
  } crtc_op_e;

  typedef enum logic [2:0] {
    GRP_NONE    = 3'd0,
    GRP_ATTR    = 3'd1,
    GRP_SEQ     = 3'd2,
    GRP_GFX     = 3'd3,
    GRP_MISC    = 3'd4,
    GRP_FEATURE = 3'd5
  } grp_e;

  // offsets within a crtc group and the 3Cx group
  localparam logic [3:0] SelStatus1   = 4'd10;
  localparam logic [3:0] SelAttr      = 4'd0;
  localparam logic [3:0] SelMisc      = 4'd2;
  localparam logic [3:0] SelSeqIdx    = 4'd4;
  localparam logic [3:0] SelSeqData   = 4'd5;
  localparam logic [3:0] SelGfxIdx    = 4'd14;
  localparam logic [3:0] SelGfxData   = 4'd15;
  localparam logic [3:0] SelCrtcLast  = 4'd7;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] port_offset;
    logic [7:0] write_data;
    logic       sync_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] crtc_op;
    logic [7:0] crtc_data;
    logic [2:0] reg_write_group;
    logic [4:0] reg_write_index;
    logic [7:0] reg_write_value;
    logic [7:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic result_held;
  } dp_status_t;

endpackage

>>> hw/rtl/gaior_stream_if.sv
// ----------------------------------------------------------------------------
// gaior_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ----------------------------------------------------------------------------
interface gaior_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/gaior_ctrl.sv
// ----------------------------------------------------------------------------
// gaior_ctrl
// Handshake controller: tracks whether a result beat is held in the output
// register and issues the execute command to the datapath.
// ----------------------------------------------------------------------------
module gaior_ctrl
  import gaior_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  output dp_status_t status_o
);

  ctl_state_e state_q, state_d;
  logic       exec;

  assign exec = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (exec) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (!exec && out_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_comb begin
    in_ready_o           = 1'b0;
    out_valid_o          = 1'b0;
    status_o.result_held = 1'b0;
    case (state_q)
      ST_EMPTY: begin
        in_ready_o = 1'b1;
      end
      ST_FULL: begin
        in_ready_o           = out_ready_i;
        out_valid_o          = 1'b1;
        status_o.result_held = 1'b1;
      end
      default: ;
    endcase
    cmd_o.exec = exec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> state_q == ST_FULL)
    else $error("accepted beat did not fill output register");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FULL && out_ready_i && !in_valid_i) |=> state_q == ST_EMPTY)
    else $error("taken result not released");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FULL && !out_ready_i) |-> !exec)
    else $error("held result overwritten");

endmodule

>>> hw/rtl/gaior_dp.sv
// ----------------------------------------------------------------------------
// gaior_dp
// Decode and register datapath: port decode, index/data flip-flop, index
// registers, sync flags, frame counter and the registered result beat.
// ----------------------------------------------------------------------------
module gaior_dp
  import gaior_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  dp_status_t status_i,
  input  in_item_t   item_i,
  output out_item_t  result_o
);

  logic                misc_q, misc_d;
  logic [1:0]          feature_q, feature_d;
  logic [AttrIdxW-1:0] attr_idx_q, attr_idx_d;
  logic                expect_idx_q, expect_idx_d;
  logic [SeqIdxW-1:0]  seq_idx_q, seq_idx_d;
  logic [GfxIdxW-1:0]  gfx_idx_q, gfx_idx_d;
  logic                vsync_q, vsync_d;
  logic                hsync_q, hsync_d;
  logic [7:0]          frames_q, frames_d;
  out_item_t           res_q, res_d;

  logic       wr;
  logic       crtc_hit;
  logic       ctl_hit;
  logic [3:0] sel;
  logic [7:0] wd;

  always_comb begin
    misc_d       = misc_q;
    feature_d    = feature_q;
    attr_idx_d   = attr_idx_q;
    expect_idx_d = expect_idx_q;
    seq_idx_d    = seq_idx_q;
    gfx_idx_d    = gfx_idx_q;
    vsync_d      = vsync_q;
    hsync_d      = hsync_q;
    frames_d     = frames_q;

    res_d                 = '0;
    res_d.read_data       = ByteOnes;
    res_d.crtc_op         = CRTC_NONE;
    res_d.reg_write_group = GRP_NONE;

    wr  = (item_i.command == CMD_IO_WRITE);
    sel = item_i.port_offset[3:0];
    wd  = item_i.write_data;

    crtc_hit = ((item_i.port_offset inside {[6'd0:6'd11]}) && !misc_q) ||
               ((item_i.port_offset inside {[6'd32:6'd43]}) && misc_q);
    ctl_hit  = (item_i.port_offset[5:4] == 2'b01);

    case (item_i.command)
      CMD_HSYNC: begin
        hsync_d = item_i.sync_level;
      end
      CMD_VSYNC: begin
        if (item_i.sync_level && !vsync_q) frames_d = frames_q + 8'd1;
        vsync_d = item_i.sync_level;
      end
      default: begin
        if (crtc_hit) begin
          if (sel <= SelCrtcLast) begin
            if (wr) begin
              res_d.crtc_op   = sel[0] ? CRTC_DATA_WR : CRTC_ADDR_WR;
              res_d.crtc_data = wd;
            end else if (sel[0]) begin
              res_d.crtc_op = CRTC_DATA_RD;
            end
          end else if (sel == SelStatus1) begin
            if (wr) begin
              feature_d             = wd[1:0];
              res_d.reg_write_group = GRP_FEATURE;
              res_d.reg_write_value = wd;
            end else begin
              res_d.read_data = {4'b0000, vsync_q, 2'b00, hsync_q};
              expect_idx_d    = 1'b1;
            end
          end
        end else if (ctl_hit) begin
          if (!wr) begin
            if (sel == SelMisc) begin
              res_d.read_data = {~vsync_q, feature_q, 1'b0, 4'hF};
            end
          end else begin
            case (sel)
              SelAttr: begin
                if (expect_idx_q) begin
                  attr_idx_d = wd[AttrIdxW-1:0];
                end else begin
                  res_d.reg_write_group = GRP_ATTR;
                  res_d.reg_write_index = 5'(attr_idx_q);
                  res_d.reg_write_value = wd;
                end
                expect_idx_d = ~expect_idx_q;
              end
              SelMisc: begin
                misc_d                = wd[0];
                res_d.reg_write_group = GRP_MISC;
                res_d.reg_write_value = wd;
              end
              SelSeqIdx: begin
                seq_idx_d = wd[SeqIdxW-1:0];
              end
              SelSeqData: begin
                res_d.reg_write_group = GRP_SEQ;
                res_d.reg_write_index = 5'(seq_idx_q);
                res_d.reg_write_value = wd;
              end
              SelGfxIdx: begin
                gfx_idx_d = wd[GfxIdxW-1:0];
              end
              SelGfxData: begin
                res_d.reg_write_group = GRP_GFX;
                res_d.reg_write_index = 5'(gfx_idx_q);
                res_d.reg_write_value = wd;
              end
              default: ;
            endcase
          end
        end
      end
    endcase

    res_d.frame_count = frames_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      misc_q       <= 1'b0;
      feature_q    <= '0;
      attr_idx_q   <= '0;
      expect_idx_q <= 1'b1;
      seq_idx_q    <= '0;
      gfx_idx_q    <= '0;
      vsync_q      <= 1'b0;
      hsync_q      <= 1'b0;
      frames_q     <= '0;
    end else if (cmd_i.exec) begin
      misc_q       <= misc_d;
      feature_q    <= feature_d;
      attr_idx_q   <= attr_idx_d;
      expect_idx_q <= expect_idx_d;
      seq_idx_q    <= seq_idx_d;
      gfx_idx_q    <= gfx_idx_d;
      vsync_q      <= vsync_d;
      hsync_q      <= hsync_d;
      frames_q     <= frames_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res_d;
  end

  assign result_o = res_q;

  a_frame_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && item_i.command == CMD_VSYNC && item_i.sync_level && !vsync_q)
    |=> frames_q == $past(frames_q) + 8'd1)
    else $error("vsync rise did not advance frame count");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(frames_q) && $stable(misc_q) && $stable(expect_idx_q))
    else $error("state changed without an accepted beat");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_i.result_held && !cmd_i.exec) |=> $stable(res_q))
    else $error("held result changed");

  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && res_d.reg_write_group != GRP_NONE) |-> res_d.crtc_op == CRTC_NONE)
    else $error("register write and crtc forward in one beat");

endmodule

>>> hw/rtl/graphics_adapter_io_registers_core.sv
// ----------------------------------------------------------------------------
// graphics_adapter_io_registers_core
// EGA-style I/O register interface: port decode, index/data registers,
// sync status and frame counting, with register-write strobes per beat.
// ----------------------------------------------------------------------------
// Each input beat (an I/O read or write on ports 3B0h-3DFh, or a sync level
// change) yields exactly one result beat, registered and valid in the cycle after it is
// accepted. A new beat is accepted every cycle while the output register is
// empty or being taken, so the sustained rate is one beat per cycle; the
// figure is set by the single state update that each beat makes to the index,
// flag and counter registers. CRTC register contents live outside the block;
// CRTC accesses are forwarded on crtc_op and crtc_data.
module graphics_adapter_io_registers_core
  import gaior_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  gaior_stream_if.sink   in_i,
  gaior_stream_if.source out_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  out_item_t  result;

  gaior_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (dp_cmd),
    .status_o    (dp_status)
  );

  gaior_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .status_i (dp_status),
    .item_i   (in_i.data),
    .result_o (result)
  );

  assign out_o.data = result;

endmodule

>>> tb/graphics_adapter_io_registers_core_checker.sv
// ----------------------------------------------------------------------------
// graphics_adapter_io_registers_core_checker
// Watches both channels of the I/O register block. Every accepted input
// beat runs through a cycle-free model of the port decode, the index/data
// register files, the sync flags and the frame counter. The predicted result
// is queued and compared field by field with the next accepted result beat.
// ----------------------------------------------------------------------------
module graphics_adapter_io_registers_core_checker
  import gaior_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gaior_stream_if     in_i,
  gaior_stream_if     out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] MonoEnd = 6'd12;
  localparam logic [5:0] CtlBase = 6'd16;
  localparam logic [5:0] ColBase = 6'd32;
  localparam logic [5:0] ColEnd  = 6'd44;

  localparam logic [7:0] DefaultPalette [16] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h14, 8'h07,
    8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F
  };

  logic [7:0] misc_q;
  logic [7:0] feature_q;
  logic [7:0] attr_idx_q;
  logic       attr_wait_index_q;
  logic [7:0] attr_file_q [AttrRegs];
  logic [7:0] seq_idx_q;
  logic [7:0] seq_file_q [SeqRegs];
  logic [7:0] gfx_idx_q;
  logic [7:0] gfx_file_q [GfxRegs];
  logic       vsync_q;
  logic       hsync_q;
  logic [7:0] frames_q;

  out_item_t result_q [$];
  out_item_t predicted;
  out_item_t wanted;
  out_item_t seen;

  task automatic report(input string msg);
    $display("%0t ns: io register check: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report($sformatf("%s got %02h, expected %02h", name, got, want));
  endtask

  // one crtc group seen through its offset 0..11
  task automatic crtc_access(input logic wr, input logic [3:0] sel, input logic [7:0] wd,
                             inout out_item_t r);
    if (sel <= SelCrtcLast) begin
      if (!sel[0]) begin
        if (wr) begin
          r.crtc_op   = CRTC_ADDR_WR;
          r.crtc_data = wd;
        end
      end else if (wr) begin
        r.crtc_op   = CRTC_DATA_WR;
        r.crtc_data = wd;
      end else begin
        r.crtc_op = CRTC_DATA_RD;
      end
    end else if (sel == SelStatus1) begin
      if (wr) begin
        feature_q         = wd;
        r.reg_write_group = GRP_FEATURE;
        r.reg_write_value = wd;
      end else begin
        r.read_data       = {4'b0000, vsync_q, 2'b00, hsync_q};
        attr_wait_index_q = 1'b1;
      end
    end
  endtask

  task automatic ctl_access(input logic wr, input logic [3:0] sel, input logic [7:0] wd,
                            inout out_item_t r);
    logic [AttrIdxW-1:0] ai;
    logic [SeqIdxW-1:0]  si;
    logic [GfxIdxW-1:0]  gi;
    ai = attr_idx_q[AttrIdxW-1:0];
    si = seq_idx_q[SeqIdxW-1:0];
    gi = gfx_idx_q[GfxIdxW-1:0];
    if (!wr) begin
      if (sel == SelMisc)
        r.read_data = {~vsync_q, feature_q[1:0], 5'h0F};
    end else begin
      case (sel)
        SelAttr: begin
          if (attr_wait_index_q) begin
            attr_idx_q = wd;
          end else begin
            attr_file_q[ai]   = wd;
            r.reg_write_group = GRP_ATTR;
            r.reg_write_index = 5'(ai);
            r.reg_write_value = wd;
          end
          attr_wait_index_q = ~attr_wait_index_q;
        end
        SelMisc: begin
          misc_q            = wd;
          r.reg_write_group = GRP_MISC;
          r.reg_write_value = wd;
        end
        SelSeqIdx: seq_idx_q = wd;
        SelSeqData: begin
          seq_file_q[si]    = wd;
          r.reg_write_group = GRP_SEQ;
          r.reg_write_index = 5'(si);
          r.reg_write_value = wd;
        end
        SelGfxIdx: gfx_idx_q = wd;
        SelGfxData: begin
          gfx_file_q[gi]    = wd;
          r.reg_write_group = GRP_GFX;
          r.reg_write_index = 5'(gi);
          r.reg_write_value = wd;
        end
        default: ;
      endcase
    end
  endtask

  task automatic predict_io_result(input in_item_t b, output out_item_t r);
    logic       wr;
    logic       colour;
    logic [5:0] rel;
    r                 = '0;
    r.read_data       = ByteOnes;
    r.crtc_op         = CRTC_NONE;
    r.reg_write_group = GRP_NONE;
    wr     = (b.command == CMD_IO_WRITE);
    colour = misc_q[0];
    case (b.command)
      CMD_HSYNC: hsync_q = b.sync_level;
      CMD_VSYNC: begin
        if (b.sync_level && !vsync_q)
          frames_q = frames_q + 8'd1;
        vsync_q = b.sync_level;
      end
      default: begin
        if (b.port_offset < MonoEnd) begin
          if (!colour)
            crtc_access(wr, b.port_offset[3:0], b.write_data, r);
        end else if (b.port_offset >= CtlBase && b.port_offset < ColBase) begin
          rel = b.port_offset - CtlBase;
          ctl_access(wr, rel[3:0], b.write_data, r);
        end else if (b.port_offset >= ColBase && b.port_offset < ColEnd && colour) begin
          rel = b.port_offset - ColBase;
          crtc_access(wr, rel[3:0], b.write_data, r);
        end
      end
    endcase
    r.frame_count = frames_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      misc_q            = '0;
      feature_q         = '0;
      attr_idx_q        = '0;
      attr_wait_index_q = 1'b1;
      for (int i = 0; i < AttrRegs; i++)
        attr_file_q[i] = (i < 16) ? DefaultPalette[i] : 8'h00;
      seq_idx_q = '0;
      for (int i = 0; i < SeqRegs; i++)
        seq_file_q[i] = '0;
      gfx_idx_q = '0;
      for (int i = 0; i < GfxRegs; i++)
        gfx_file_q[i] = '0;
      vsync_q  = 1'b0;
      hsync_q  = 1'b0;
      frames_q = '0;
      result_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        seen = out_i.data;
        if (result_q.size() == 0) begin
          report("result beat with no prediction pending");
        end else begin
          wanted = result_q.pop_front();
          check_field("read_data", seen.read_data, wanted.read_data);
          check_field("crtc_op", 8'(seen.crtc_op), 8'(wanted.crtc_op));
          check_field("crtc_data", seen.crtc_data, wanted.crtc_data);
          check_field("reg_write_group", 8'(seen.reg_write_group), 8'(wanted.reg_write_group));
          check_field("reg_write_index", 8'(seen.reg_write_index), 8'(wanted.reg_write_index));
          check_field("reg_write_value", seen.reg_write_value, wanted.reg_write_value);
          check_field("frame_count", seen.frame_count, wanted.frame_count);
        end
      end
      if (in_i.valid && in_i.ready) begin
        predict_io_result(in_i.data, predicted);
        result_q.push_back(predicted);
      end
      pending_o = result_q.size();
    end
  end

endmodule

>>> tb/graphics_adapter_io_registers_core_test.sv
// ----------------------------------------------------------------------------
// graphics_adapter_io_registers_core_test
// Drives the I/O register block with a directed opening (attribute flip-flop,
// index/data pairs, crtc forwarding, status and feature reads, sync flags,
// group switching), then random register sequences and a long vsync toggle
// run that wraps the frame counter. Both sides stall at random, bar one span.
// ----------------------------------------------------------------------------
module graphics_adapter_io_registers_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gaior_pkg::*;

  localparam logic [5:0]  OffMono   = 6'd0;
  localparam logic [5:0]  OffCtl    = 6'd16;
  localparam logic [5:0]  OffCol    = 6'd32;
  localparam int unsigned MixedBeats  = 800;
  localparam int unsigned ToggleBeats = 520;
  localparam int unsigned SteadyFrom  = 700;
  localparam int unsigned SteadyTo    = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        steady;
  int unsigned sent;
  int unsigned fail_count;
  int unsigned pending_beats;

  gaior_stream_if #(.T(in_item_t))  in_if ();
  gaior_stream_if #(.T(out_item_t)) out_if ();

  graphics_adapter_io_registers_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  graphics_adapter_io_registers_core_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= rst_ni && (steady || $urandom_range(99) >= 26);
    end
  end

  task automatic send(input cmd_e c, input logic [5:0] off, input logic [7:0] wd,
                      input logic lvl);
    in_item_t b;
    b.command     = c;
    b.port_offset = off;
    b.write_data  = wd;
    b.sync_level  = lvl;
    while (!steady && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    @(posedge clk_i);
    while (!in_if.ready)
      @(posedge clk_i);
    sent++;
    steady = (sent >= SteadyFrom && sent < SteadyTo);
    @(negedge clk_i);
  endtask

  task automatic io_wr(input logic [5:0] off, input logic [7:0] wd);
    send(CMD_IO_WRITE, off, wd, 1'($urandom_range(1)));
  endtask

  task automatic io_rd(input logic [5:0] off);
    send(CMD_IO_READ, off, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic random_sequence();
    int unsigned pick;
    logic [5:0]  base;
    pick = $urandom_range(99);
    base = $urandom_range(1) ? OffCol : OffMono;
    if (pick < 12) begin
      io_wr(OffCtl + SelAttr, 8'($urandom_range(255)));
      io_wr(OffCtl + SelAttr, 8'($urandom_range(255)));
    end else if (pick < 22) begin
      io_wr(OffCtl + SelSeqIdx, 8'($urandom_range(255)));
      io_wr(OffCtl + SelSeqData, 8'($urandom_range(255)));
    end else if (pick < 32) begin
      io_wr(OffCtl + SelGfxIdx, 8'($urandom_range(255)));
      io_wr(OffCtl + SelGfxData, 8'($urandom_range(255)));
    end else if (pick < 40) begin
      io_rd(base + SelStatus1);
    end else if (pick < 46) begin
      io_wr(OffCtl + SelMisc, 8'($urandom_range(255)));
    end else if (pick < 52) begin
      io_rd(OffCtl + SelMisc);
    end else if (pick < 66) begin
      send($urandom_range(1) ? CMD_IO_WRITE : CMD_IO_READ, base + 6'($urandom_range(11)),
           8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 76) begin
      send($urandom_range(1) ? CMD_VSYNC : CMD_HSYNC, 6'($urandom_range(63)),
           8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      send(cmd_e'($urandom_range(3)), 6'($urandom_range(63)), 8'($urandom_range(255)),
           1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    steady      = 1'b0;
    sent        = 0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    io_rd(OffCtl + SelMisc);
    io_wr(OffCtl + SelAttr, 8'hFF);
    io_wr(OffCtl + SelAttr, 8'hFF);
    io_wr(OffCtl + SelAttr, 8'h23);
    io_rd(OffMono + SelStatus1);
    io_wr(OffCtl + SelAttr, 8'h00);
    io_wr(OffCtl + SelAttr, 8'h00);
    io_wr(OffCtl + SelSeqIdx, 8'hFF);
    io_wr(OffCtl + SelSeqData, 8'h5A);
    io_wr(OffCtl + SelGfxIdx, 8'hFF);
    io_wr(OffCtl + SelGfxData, 8'hC3);
    io_wr(OffMono, 8'hFF);
    io_rd(OffMono + SelCrtcLast);
    io_rd(OffMono + 6'd6);
    io_wr(OffMono + SelStatus1, 8'hFF);
    send(CMD_VSYNC, 6'd0, 8'h00, 1'b1);
    send(CMD_VSYNC, 6'd63, 8'hFF, 1'b1);
    send(CMD_HSYNC, 6'd0, 8'h00, 1'b1);
    io_rd(OffMono + SelStatus1);
    io_rd(OffCtl + SelMisc);
    io_wr(6'd63, 8'hFF);
    io_wr(OffCtl + SelMisc, 8'h01);
    io_rd(OffCol + 6'd1);
    io_rd(OffMono + 6'd1);
    io_wr(OffCol + SelStatus1, 8'h00);

    while (sent < MixedBeats)
      random_sequence();

    // long vsync toggle run to wrap the frame counter
    for (int unsigned i = 0; i < ToggleBeats; i++)
      send(CMD_VSYNC, 6'($urandom_range(63)), 8'($urandom_range(255)),
           (i % 2 == 0) ? 1'b1 : 1'b0);

    in_if.valid <= 1'b0;
    while (pending_beats != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0)
      $display("** graphics_adapter_io_registers_core: PASSED **");
    else
      $display("** graphics_adapter_io_registers_core: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** graphics_adapter_io_registers_core: FAILED **");
    $finish;
  end

endmodule
